/* design/arpb_pkg.sv */
// Package for the affine rectification point and box mapper.
// Holds widths, payload structs and register indexes; no dependencies.
package arpb_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int LINE_WIDTH      = 32;
    localparam int LINE_FRAC_BITS  = 30;
    localparam int FRAC_SHIFT      = COORD_FRAC_BITS + LINE_FRAC_BITS;
    localparam int PROD_W          = LINE_WIDTH + COORD_WIDTH;
    localparam int W_W             = PROD_W + 2;
    localparam int QUO_W           = COORD_WIDTH + 1;
    localparam int REM_W           = W_W + QUO_W;
    localparam int DIV_LAT         = QUO_W + 2;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = LINE_WIDTH;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_A,
        REG_LINE_B
    } t_reg_idx;

    typedef struct packed {
        logic                   mode;
        logic [COORD_WIDTH-1:0] x_lo;
        logic [COORD_WIDTH-1:0] y_lo;
        logic [COORD_WIDTH-1:0] x_hi;
        logic [COORD_WIDTH-1:0] y_hi;
    } t_in;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] out_x;
        logic [COORD_WIDTH-1:0] out_y;
        logic [COORD_WIDTH-1:0] box_min_x;
        logic [COORD_WIDTH-1:0] box_max_x;
        logic [COORD_WIDTH-1:0] box_min_y;
        logic [COORD_WIDTH-1:0] box_max_y;
        logic                   past_horizon;
    } t_out;

endpackage

/* design/arpb_div.sv */
// Pipelined restoring divider with rounding and saturation, one quotient bit per stage.
// Depends on arpb_pkg.
module arpb_div import arpb_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [COORD_WIDTH-1:0] i_num,
    input  logic [W_W-1:0]         i_den,
    output logic [COORD_WIDTH-1:0] o_quo
);

    localparam logic [QUO_W-1:0] LIM_P = QUO_W'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
    localparam logic [QUO_W-1:0] LIM_N = QUO_W'(64'd1 << (COORD_WIDTH - 1));
    localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [COORD_WIDTH-1:0] an;
    logic [W_W-1:0]         ad;
    logic [REM_W-1:0]       n_r0;

    logic [REM_W-1:0] r_r   [0:QUO_W];
    logic [W_W-1:0]   r_d   [0:QUO_W];
    logic [QUO_W-1:0] r_q   [0:QUO_W];
    logic             r_ovf [0:QUO_W];
    logic             r_neg [0:QUO_W];
    logic             r_dz  [0:QUO_W];
    logic             r_nz  [0:QUO_W];

    logic [REM_W-1:0] n_r   [0:QUO_W-1];
    logic [QUO_W-1:0] n_q   [0:QUO_W-1];
    logic             n_ovf [0:QUO_W-1];

    logic [COORD_WIDTH-1:0] r_quo;
    logic [COORD_WIDTH-1:0] n_quo;
    logic [QUO_W-1:0]       q;
    logic                   big;

    always_comb begin
        an   = i_num[COORD_WIDTH-1] ? (COORD_WIDTH'(0) - i_num) : i_num;
        ad   = i_den[W_W-1] ? (W_W'(0) - i_den) : i_den;
        n_r0 = (REM_W'(an) << (FRAC_SHIFT + 1)) + REM_W'(ad);
    end

    for (genvar k = 0; k < QUO_W; k++) begin : g_step
        logic [REM_W-1:0] sh;
        logic             ge;
        always_comb begin
            sh       = REM_W'(r_d[k]) << (QUO_W - 1 - k);
            ge       = r_r[k] >= sh;
            n_r[k]   = ge ? (r_r[k] - sh) : r_r[k];
            n_q[k]   = {r_q[k][QUO_W-2:0], ge};
        end
        if (k == 0) begin : g_ovf
            assign n_ovf[k] = r_r[0] >= (REM_W'(r_d[0]) << QUO_W);
        end else begin : g_keep
            assign n_ovf[k] = r_ovf[k];
        end
    end

    always_comb begin
        q   = r_q[QUO_W];
        big = r_ovf[QUO_W] || (r_neg[QUO_W] ? (q > LIM_N) : (q > LIM_P));
        if (r_dz[QUO_W]) begin
            n_quo = r_nz[QUO_W] ? '0 : (r_neg[QUO_W] ? SAT_MIN : SAT_MAX);
        end else if (big) begin
            n_quo = r_neg[QUO_W] ? SAT_MIN : SAT_MAX;
        end else begin
            n_quo = r_neg[QUO_W] ? (COORD_WIDTH'(0) - q[COORD_WIDTH-1:0])
                                 : q[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r[0]   <= n_r0;
            r_d[0]   <= ad << 1;
            r_q[0]   <= '0;
            r_ovf[0] <= 1'b0;
            r_neg[0] <= i_num[COORD_WIDTH-1] ^ i_den[W_W-1];
            r_dz[0]  <= (i_den == '0);
            r_nz[0]  <= (i_num == '0);
            for (int k = 0; k < QUO_W; k++) begin
                r_r[k+1]   <= n_r[k];
                r_d[k+1]   <= r_d[k];
                r_q[k+1]   <= n_q[k];
                r_ovf[k+1] <= n_ovf[k];
                r_neg[k+1] <= r_neg[k];
                r_dz[k+1]  <= r_dz[k];
                r_nz[k+1]  <= r_nz[k];
            end
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

/* design/affine_rectify_point_and_bbox.sv */
// A request passes the input, product and denominator registers, the dividers and the output register.
// Throughput: one request per cycle; all stages advance together and hold on a stall.
// The rate is set by the eight pipelined dividers, one quotient bit per stage.
// Reset (synchronous, active low) clears all valid bits and both line coefficients.
// Top level of the affine rectification mapper; depends on arpb_pkg and arpb_div.
module affine_rectify_point_and_bbox import arpb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic signed [W_W-1:0] ONE = W_W'(1) << FRAC_SHIFT;

    logic en;

    logic [LINE_WIDTH-1:0] r_line_a;
    logic [LINE_WIDTH-1:0] r_line_b;

    logic r1_v;
    t_in  r1;
    logic r2_v;
    t_in  r2;
    logic signed [PROD_W-1:0] r2_axl, r2_axh, r2_byl, r2_byh;
    logic r3_v;
    t_in  r3;
    logic [W_W-1:0] r3_w [0:3];
    logic           r3_f;

    logic signed [W_W-1:0] t [0:3];
    logic [W_W-1:0]        n_w [0:3];
    logic [3:0]            np;
    logic                  n_f;

    logic [DIV_LAT-1:0] r_vd, r_md, r_fd;

    logic [COORD_WIDTH-1:0] cx [0:3];
    logic [COORD_WIDTH-1:0] cy [0:3];
    logic [COORD_WIDTH-1:0] qx [0:3];
    logic [COORD_WIDTH-1:0] qy [0:3];

    logic r_ov;
    logic r_om;
    t_out r_out;
    t_out n_out;

    function automatic logic [COORD_WIDTH-1:0] smin(input logic [COORD_WIDTH-1:0] a,
                                                    input logic [COORD_WIDTH-1:0] b);
        return ($signed(b) < $signed(a)) ? b : a;
    endfunction

    function automatic logic [COORD_WIDTH-1:0] smax(input logic [COORD_WIDTH-1:0] a,
                                                    input logic [COORD_WIDTH-1:0] b);
        return ($signed(a) < $signed(b)) ? b : a;
    endfunction

    assign en          = !r_ov || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_ov;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_a <= '0;
            r_line_b <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_LINE_A: r_line_a <= i_cfg_data;
                REG_LINE_B: r_line_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        t[0] = W_W'(r2_axl) + W_W'(r2_byl);
        t[1] = W_W'(r2_axh) + W_W'(r2_byl);
        t[2] = W_W'(r2_axh) + W_W'(r2_byh);
        t[3] = W_W'(r2_axl) + W_W'(r2_byh);
        for (int i = 0; i < 4; i++) begin
            n_w[i] = r2.mode ? (ONE + t[i]) : (ONE - t[i]);
            np[i]  = n_w[i][W_W-1] || (n_w[i] == '0);
        end
        n_f = r2.mode ? (|np) : np[0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r_vd <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r_vd <= {r_vd[DIV_LAT-2:0], r3_v};
            r_ov <= r_vd[DIV_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1     <= i_in;
            r2     <= r1;
            r2_axl <= $signed(r_line_a) * $signed(r1.x_lo);
            r2_axh <= $signed(r_line_a) * $signed(r1.x_hi);
            r2_byl <= $signed(r_line_b) * $signed(r1.y_lo);
            r2_byh <= $signed(r_line_b) * $signed(r1.y_hi);
            r3     <= r2;
            for (int i = 0; i < 4; i++) begin
                r3_w[i] <= n_w[i];
            end
            r3_f <= n_f;
            r_md <= {r_md[DIV_LAT-2:0], r3.mode};
            r_fd <= {r_fd[DIV_LAT-2:0], r3_f};
            r_om <= r_md[DIV_LAT-1];
            if (r_vd[DIV_LAT-1]) begin
                r_out <= n_out;
            end
        end
    end

    always_comb begin
        cx[0] = r3.x_lo; cy[0] = r3.y_lo;
        cx[1] = r3.x_hi; cy[1] = r3.y_lo;
        cx[2] = r3.x_hi; cy[2] = r3.y_hi;
        cx[3] = r3.x_lo; cy[3] = r3.y_hi;
    end

    for (genvar i = 0; i < 4; i++) begin : g_corner
        arpb_div u_div_x (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (cx[i]),
            .i_den (r3_w[i]),
            .o_quo (qx[i])
        );
        arpb_div u_div_y (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (cy[i]),
            .i_den (r3_w[i]),
            .o_quo (qy[i])
        );
    end

    always_comb begin
        n_out              = '0;
        n_out.past_horizon = r_fd[DIV_LAT-1];
        if (!r_md[DIV_LAT-1]) begin
            n_out.out_x = qx[0];
            n_out.out_y = qy[0];
        end else begin
            n_out.box_min_x = smin(smin(qx[0], qx[1]), smin(qx[2], qx[3]));
            n_out.box_max_x = smax(smax(qx[0], qx[1]), smax(qx[2], qx[3]));
            n_out.box_min_y = smin(smin(qy[0], qy[1]), smin(qy[2], qy[3]));
            n_out.box_max_y = smax(smax(qy[0], qy[1]), smax(qy[2], qy[3]));
        end
    end

    a_point_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_om) |-> (r_out.box_min_x == '0 && r_out.box_max_x == '0 &&
                             r_out.box_min_y == '0 && r_out.box_max_y == '0))
        else $error("point result carries a nonzero box");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_om) |-> (r_out.out_x == '0 && r_out.out_y == '0 &&
                            $signed(r_out.box_min_x) <= $signed(r_out.box_max_x) &&
                            $signed(r_out.box_min_y) <= $signed(r_out.box_max_y)))
        else $error("box result is malformed");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_vd) && $stable(r3_v) && $stable(r2_v) && $stable(r1_v)))
        else $error("pipeline valid bits moved during a stall");

endmodule
